FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the profile time accounting block.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pta_pkg.sv
// Package for the profile time accounting block: operation and read codes,
// default table sizes and the packed input item. No dependencies.
`default_nettype none

package pta_pkg;

  localparam int NUM_BUCKETS_DEF  = 64;
  localparam int NUM_PROBES_DEF   = 32;
  localparam int NUM_SYSCALLS_DEF = 64;

  localparam int BUCKET_W = 6;
  localparam int INDEX_W  = 16;
  localparam int TIME_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int IN_W     = 152;
  localparam int OUT_W    = 104;

  localparam logic [2:0] OP_SWITCH  = 3'd0;
  localparam logic [2:0] OP_PROBE   = 3'd1;
  localparam logic [2:0] OP_SYSCALL = 3'd2;
  localparam logic [2:0] OP_SLEEP   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [2:0] TGT_BUCKET  = 3'd0;
  localparam logic [2:0] TGT_PROBE   = 3'd1;
  localparam logic [2:0] TGT_SYSCALL = 3'd2;
  localparam logic [2:0] TGT_SLEEP   = 3'd3;
  localparam logic [2:0] TGT_ELAPSED = 3'd4;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]         pad;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  start_time;
    logic [2:0]         read_target;
    logic [INDEX_W-1:0] index;
    logic [2:0]         operation;
  } item_t;

endpackage

`default_nettype wire

FILE: hdl/pta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module pta_ram #(
  parameter  int WIDTH  = 64,
  parameter  int DEPTH  = 224,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/profile_time_accounting.sv
// Profile time accounting: cycle and event tables for kernel profiling.
// Depends on pta_pkg, pta_ram and assert_macros.svh.
//
// Usage:
//   s_* carries one event per transaction (operation, index, read target,
//   start and now timestamps); m_* returns exactly one result per event
//   (previous bucket, read cycles, read count). cfg_* writes initial_bucket
//   and is always ready outside reset; write it only while the block is idle.
//   All counters live in two RAMs (sums and counts) laid out as bucket,
//   probe, syscall and sleep regions. Each event reads its entries in the
//   accept cycle and writes them back in the modify state, which holds while
//   the output register is full; no new event is accepted until the
//   read-modify-write is done.
//   A clear zeroes both RAMs one entry per cycle, sweeping all
//   NUM_BUCKETS + NUM_PROBES + 2*NUM_SYSCALLS entries (224 by default).
//   After reset the same sweep runs with s_tready low; cfg writes are
//   taken meanwhile.
//   A finished result sits in the output register; the next event is
//   accepted while it waits, and the write-back holds until m_tready frees
//   the register.
`include "assert_macros.svh"
`default_nettype none

module profile_time_accounting
  import pta_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int NUM_PROBES   = NUM_PROBES_DEF,
  parameter int NUM_SYSCALLS = NUM_SYSCALLS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // operation[2:0], index[18:3], read_target[21:19], start_time[85:22],
  // now_time[149:86], zero[151:150]
  input  wire logic [IN_W-1:0]     s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // previous_bucket[5:0], read_cycles[69:6], read_count[101:70], zero[103:102]
  output logic      [OUT_W-1:0]    m_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [BUCKET_W-1:0] cfg_data
);

  localparam int PROBE_BASE = NUM_BUCKETS;
  localparam int SYS_BASE   = NUM_BUCKETS + NUM_PROBES;
  localparam int SLEEP_BASE = NUM_BUCKETS + NUM_PROBES + NUM_SYSCALLS;
  localparam int TOTAL      = NUM_BUCKETS + NUM_PROBES + 2 * NUM_SYSCALLS;
  localparam int AW         = $clog2(TOTAL);
  localparam int BKW        = $clog2(NUM_BUCKETS);
  localparam int PW         = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
  localparam int SW         = $clog2(NUM_SYSCALLS);
  localparam int CW         = (BKW > BUCKET_W) ? BKW : BUCKET_W;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;

  logic [1:0]          state;
  logic [AW-1:0]       sweep_addr;
  logic                sweep_reply;

  logic [CW-1:0]       current_bucket;
  logic [TIME_W-1:0]   last_switch_time;
  logic [TIME_W-1:0]   start_of_count_time;
  logic                timing_running;

  // Per-event work registered at accept
  logic [AW-1:0]       sum_addr;
  logic [AW-1:0]       cnt_addr;
  logic                sum_we;
  logic                cnt_we;
  logic                sel_sum;
  logic                sel_cnt;
  logic                sel_delta;
  logic [TIME_W-1:0]   delta;
  logic [CW-1:0]       prev_bucket;

  logic [AW-1:0]       sum_addr_next;
  logic [AW-1:0]       cnt_addr_next;
  logic                sum_we_next;
  logic                cnt_we_next;
  logic                sel_sum_next;
  logic                sel_cnt_next;
  logic                sel_delta_next;
  logic [TIME_W-1:0]   delta_next;

  logic [TIME_W-1:0]   sum_rd;
  logic [COUNT_W-1:0]  cnt_rd;
  logic                ram_sum_we;
  logic                ram_cnt_we;
  logic [AW-1:0]       ram_sum_waddr;
  logic [AW-1:0]       ram_cnt_waddr;
  logic [TIME_W-1:0]   ram_sum_wdata;
  logic [COUNT_W-1:0]  ram_cnt_wdata;

  item_t               item;
  logic                accept;
  logic                out_ok;
  logic                in_bkt;
  logic                in_prb;
  logic                in_sys;
  logic                cur_in;
  logic                switch_take;
  logic [SW-1:0]       sys_clamped;

  assign item      = item_t'(s_tdata);
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_ok    = !m_tvalid || m_tready;

  assign in_bkt = {1'b0, item.index} < (INDEX_W + 1)'(NUM_BUCKETS);
  assign in_prb = {1'b0, item.index} < (INDEX_W + 1)'(NUM_PROBES);
  assign in_sys = {1'b0, item.index} < (INDEX_W + 1)'(NUM_SYSCALLS);
  assign cur_in = {1'b0, current_bucket} < (CW + 1)'(NUM_BUCKETS);
  assign sys_clamped = in_sys ? item.index[SW-1:0] : SW'(NUM_SYSCALLS - 1);
  assign switch_take = accept && (item.operation == OP_SWITCH) && in_bkt;

  always_comb begin
    sum_addr_next  = '0;
    cnt_addr_next  = '0;
    sum_we_next    = 1'b0;
    cnt_we_next    = 1'b0;
    sel_sum_next   = 1'b0;
    sel_cnt_next   = 1'b0;
    sel_delta_next = 1'b0;
    delta_next     = '0;
    case (item.operation)
      OP_SWITCH: begin
        // first switch only starts timing, no table touched
        if (in_bkt && timing_running) begin
          sum_we_next   = cur_in;
          sum_addr_next = AW'(current_bucket[BKW-1:0]);
          delta_next    = item.now_time - last_switch_time;
          cnt_we_next   = 1'b1;
          cnt_addr_next = AW'(item.index[BKW-1:0]);
        end
      end
      OP_PROBE: begin
        if (in_prb) begin
          sum_addr_next = AW'(PROBE_BASE) + AW'(item.index[PW-1:0]);
          cnt_addr_next = AW'(PROBE_BASE) + AW'(item.index[PW-1:0]);
          sum_we_next   = 1'b1;
          cnt_we_next   = 1'b1;
          delta_next    = item.now_time - item.start_time;
        end
      end
      OP_SYSCALL: begin
        cnt_addr_next = AW'(SYS_BASE) + AW'(sys_clamped);
        cnt_we_next   = 1'b1;
      end
      OP_SLEEP: begin
        sum_addr_next = AW'(SLEEP_BASE) + AW'(sys_clamped);
        cnt_addr_next = AW'(SLEEP_BASE) + AW'(sys_clamped);
        sum_we_next   = 1'b1;
        cnt_we_next   = 1'b1;
        delta_next    = item.now_time - item.start_time;
      end
      OP_READ: begin
        case (item.read_target)
          TGT_BUCKET: begin
            if (in_bkt) begin
              sum_addr_next = AW'(item.index[BKW-1:0]);
              cnt_addr_next = AW'(item.index[BKW-1:0]);
              sel_sum_next  = 1'b1;
              sel_cnt_next  = 1'b1;
            end
          end
          TGT_PROBE: begin
            if (in_prb) begin
              sum_addr_next = AW'(PROBE_BASE) + AW'(item.index[PW-1:0]);
              cnt_addr_next = AW'(PROBE_BASE) + AW'(item.index[PW-1:0]);
              sel_sum_next  = 1'b1;
              sel_cnt_next  = 1'b1;
            end
          end
          TGT_SYSCALL: begin
            if (in_sys) begin
              cnt_addr_next = AW'(SYS_BASE) + AW'(item.index[SW-1:0]);
              sel_cnt_next  = 1'b1;
            end
          end
          TGT_SLEEP: begin
            if (in_sys) begin
              sum_addr_next = AW'(SLEEP_BASE) + AW'(item.index[SW-1:0]);
              cnt_addr_next = AW'(SLEEP_BASE) + AW'(item.index[SW-1:0]);
              sel_sum_next  = 1'b1;
              sel_cnt_next  = 1'b1;
            end
          end
          TGT_ELAPSED: begin
            if (timing_running) begin
              sel_delta_next = 1'b1;
              delta_next     = item.now_time - start_of_count_time;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Write port: zeros during the sweep, updated entry in the modify cycle
  always_comb begin
    if (state == ST_SWEEP) begin
      ram_sum_we    = 1'b1;
      ram_cnt_we    = 1'b1;
      ram_sum_waddr = sweep_addr;
      ram_cnt_waddr = sweep_addr;
      ram_sum_wdata = '0;
      ram_cnt_wdata = '0;
    end else begin
      ram_sum_we    = (state == ST_MOD) && out_ok && sum_we;
      ram_cnt_we    = (state == ST_MOD) && out_ok && cnt_we;
      ram_sum_waddr = sum_addr;
      ram_cnt_waddr = cnt_addr;
      ram_sum_wdata = sum_rd + delta;
      ram_cnt_wdata = cnt_rd + COUNT_W'(1);
    end
  end

  pta_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TOTAL)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (ram_sum_we),
    .wr_addr (ram_sum_waddr),
    .wr_data (ram_sum_wdata),
    .rd_en   (accept),
    .rd_addr (sum_addr_next),
    .rd_data (sum_rd)
  );

  pta_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TOTAL)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_cnt_we),
    .wr_addr (ram_cnt_waddr),
    .wr_data (ram_cnt_wdata),
    .rd_en   (accept),
    .rd_addr (cnt_addr_next),
    .rd_data (cnt_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_addr    <= sum_addr_next;
      cnt_addr    <= cnt_addr_next;
      sum_we      <= sum_we_next;
      cnt_we      <= cnt_we_next;
      sel_sum     <= sel_sum_next;
      sel_cnt     <= sel_cnt_next;
      sel_delta   <= sel_delta_next;
      delta       <= delta_next;
      prev_bucket <= current_bucket;
    end
    if ((state == ST_MOD) && out_ok) begin
      m_tdata <= {2'b00,
                  sel_cnt ? cnt_rd : COUNT_W'(0),
                  sel_sum ? sum_rd : (sel_delta ? delta : TIME_W'(0)),
                  prev_bucket[BUCKET_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_SWEEP;
      sweep_addr          <= '0;
      sweep_reply         <= 1'b0;
      m_tvalid            <= 1'b0;
      current_bucket      <= '0;
      last_switch_time    <= '0;
      start_of_count_time <= '0;
      timing_running      <= 1'b0;
    end else begin
      if ((state == ST_MOD) && out_ok) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (switch_take) begin
        current_bucket <= CW'(item.index[BKW-1:0]);
      end else if (cfg_valid && !timing_running) begin
        current_bucket <= CW'(cfg_data);
      end
      case (state)
        ST_SWEEP: begin
          if (sweep_addr == AW'(TOTAL - 1)) begin
            sweep_addr <= '0;
            state      <= sweep_reply ? ST_MOD : ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= (item.operation == OP_CLEAR) ? ST_SWEEP : ST_MOD;
            if (switch_take) begin
              if (!timing_running) begin
                timing_running      <= 1'b1;
                start_of_count_time <= item.now_time;
              end
              last_switch_time <= item.now_time;
            end
            if (item.operation == OP_CLEAR) begin
              timing_running      <= 1'b1;
              start_of_count_time <= item.now_time;
              last_switch_time    <= item.now_time;
              sweep_reply         <= 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (out_ok) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_sweep_in_range, clk, rst,
                 (state != ST_SWEEP) || (sweep_addr <= AW'(TOTAL - 1)),
                 "sweep address past table end")
  `ASSERT_NEXT(a_accept_moves_on, clk, rst, accept,
               (state == ST_MOD) || (state == ST_SWEEP),
               "accepted event left no work")
  `ASSERT_NEXT(a_writeback_has_result, clk, rst, (state == ST_MOD) && out_ok,
               m_tvalid && (state == ST_IDLE),
               "write-back without result")

endmodule

`default_nettype wire
